/* sv/mcbp_pkg.sv */
// Shared types, codes and defaults for the multi-channel byte pipe.
`timescale 1ns / 1ps
`default_nettype none
package mcbp_pkg;

	localparam int NUM_PIPES_DEF  = 4;
	localparam int PIPE_DEPTH_DEF = 8;

	localparam int OP_W     = 2;
	localparam int INDEX_W  = 2;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 4;

	typedef enum logic [OP_W-1:0] {
		OP_NOP    = 2'd0,
		OP_CREATE = 2'd1,
		OP_READ   = 2'd2,
		OP_WRITE  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_WOULD_BLOCK = 2'd1,
		ST_NOT_OPEN    = 2'd2,
		ST_NONE_FREE   = 2'd3
	} status_t;

	// Result of one request, less the byte that comes from the store.
	typedef struct packed {
		status_t              status;
		logic [INDEX_W-1:0]   opened_pipe;
		logic [FILL_W-1:0]    fill_count;
		logic                 rd_hit;
	} res_t;

endpackage
`default_nettype wire

/* sv/mcbp_store.sv */
// Byte store shared by all pipes: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module mcbp_store #(
	parameter int NUM_PIPES  = 4,
	parameter int PIPE_DEPTH = 8,
	localparam int DEPTH     = NUM_PIPES * PIPE_DEPTH,
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [mcbp_pkg::BYTE_W-1:0] wdata,
	input  wire logic                      re,
	input  wire logic [AW-1:0]             raddr,
	output      logic [mcbp_pkg::BYTE_W-1:0] rdata_s2
);
	import mcbp_pkg::*;

	logic [BYTE_W-1:0] store_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_s2 <= store_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* sv/mcbp_ctrl.sv */
// Per-pipe pointers, counts and open flags, and the decision for one request.
`timescale 1ns / 1ps
`default_nettype none
module mcbp_ctrl #(
	parameter int NUM_PIPES  = 4,
	parameter int PIPE_DEPTH = 8,
	localparam int IW        = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1,
	localparam int PW        = $clog2(PIPE_DEPTH),
	localparam int CW        = $clog2(PIPE_DEPTH + 1),
	localparam int DEPTH     = NUM_PIPES * PIPE_DEPTH,
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire logic [mcbp_pkg::OP_W-1:0]   op_s1,
	input  wire logic [mcbp_pkg::INDEX_W-1:0] idx_s1,
	output      mcbp_pkg::res_t              res,
	output      logic                        mem_we,
	output      logic                        mem_re,
	output      logic [AW-1:0]               mem_waddr,
	output      logic [AW-1:0]               mem_raddr
);
	import mcbp_pkg::*;

	logic [PW-1:0] rd_ptr_q [NUM_PIPES];
	logic [PW-1:0] wr_ptr_q [NUM_PIPES];
	logic [CW-1:0] cnt_q    [NUM_PIPES];
	logic [NUM_PIPES-1:0] open_q;

	logic [IW+INDEX_W-1:0] idx_ext;
	logic [IW-1:0]         idx;
	logic                  in_range;
	logic                  sel_open;
	logic [CW-1:0]         cnt_sel;
	logic [PW-1:0]         rd_ptr_sel;
	logic [PW-1:0]         wr_ptr_sel;
	logic [PW-1:0]         rd_ptr_nxt;
	logic [PW-1:0]         wr_ptr_nxt;
	logic [AW-1:0]         base;
	logic                  found;
	logic [IW-1:0]         free_idx;
	logic [IW+INDEX_W-1:0] free_ext;
	logic                  do_open;
	logic                  do_read;
	logic                  do_write;

	function automatic logic [FILL_W-1:0] fill4(input logic [CW-1:0] c);
		logic [CW+FILL_W-1:0] e;
		e = {{FILL_W{1'b0}}, c};
		return e[FILL_W-1:0];
	endfunction

	assign idx_ext    = {{IW{1'b0}}, idx_s1};
	assign idx        = idx_ext[IW-1:0];
	assign in_range   = idx_ext < (IW+INDEX_W)'(NUM_PIPES);
	assign sel_open   = in_range && open_q[idx];
	assign cnt_sel    = in_range ? cnt_q[idx] : '0;
	assign rd_ptr_sel = in_range ? rd_ptr_q[idx] : '0;
	assign wr_ptr_sel = in_range ? wr_ptr_q[idx] : '0;
	assign rd_ptr_nxt = (rd_ptr_sel == PW'(PIPE_DEPTH - 1)) ? '0 : rd_ptr_sel + 1'b1;
	assign wr_ptr_nxt = (wr_ptr_sel == PW'(PIPE_DEPTH - 1)) ? '0 : wr_ptr_sel + 1'b1;
	assign base       = AW'(idx) * AW'(PIPE_DEPTH);
	assign mem_raddr  = base + AW'(rd_ptr_sel);
	assign mem_waddr  = base + AW'(wr_ptr_sel);
	assign mem_we     = advance && do_write;
	assign mem_re     = advance && do_read;
	assign free_ext   = {{INDEX_W{1'b0}}, free_idx};

	// Lowest-numbered closed pipe.
	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int i = NUM_PIPES - 1; i >= 0; i--) begin
			if (!open_q[i]) begin
				found    = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	always_comb begin
		res        = '0;
		res.status = ST_OK;
		do_open    = 1'b0;
		do_read    = 1'b0;
		do_write   = 1'b0;
		unique case (op_t'(op_s1))
			OP_NOP: begin
				res.fill_count = fill4(cnt_sel);
			end
			OP_CREATE: begin
				if (found) begin
					do_open         = 1'b1;
					res.opened_pipe = free_ext[INDEX_W-1:0];
				end else begin
					res.status = ST_NONE_FREE;
				end
			end
			OP_READ: begin
				if (!sel_open) begin
					res.status = ST_NOT_OPEN;
				end else if (cnt_sel == '0) begin
					res.status = ST_WOULD_BLOCK;
				end else begin
					do_read        = 1'b1;
					res.rd_hit     = 1'b1;
					res.fill_count = fill4(cnt_sel - 1'b1);
				end
			end
			OP_WRITE: begin
				if (!sel_open) begin
					res.status = ST_NOT_OPEN;
				end else if (cnt_sel == CW'(PIPE_DEPTH)) begin
					res.status     = ST_WOULD_BLOCK;
					res.fill_count = fill4(cnt_sel);
				end else begin
					do_write       = 1'b1;
					res.fill_count = fill4(cnt_sel + 1'b1);
				end
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '{default: '0};
			wr_ptr_q <= '{default: '0};
			cnt_q    <= '{default: '0};
			open_q   <= '0;
		end else if (advance) begin
			if (do_open) begin
				open_q[free_idx]   <= 1'b1;
				rd_ptr_q[free_idx] <= '0;
				wr_ptr_q[free_idx] <= '0;
				cnt_q[free_idx]    <= '0;
			end
			if (do_read) begin
				rd_ptr_q[idx] <= rd_ptr_nxt;
				cnt_q[idx]    <= cnt_sel - 1'b1;
			end
			if (do_write) begin
				wr_ptr_q[idx] <= wr_ptr_nxt;
				cnt_q[idx]    <= cnt_sel + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/multi_channel_byte_pipe.sv */
// Top level of the multi-channel byte pipe: handshake stages, control and byte store.
//
// A set of NUM_PIPES byte pipes, each a ring buffer of PIPE_DEPTH bytes.
// Requests arrive on the s_axis channel: nop, create (open the lowest closed
// pipe), read one byte or write one byte to the pipe named by pipe_index.
// Every request gives exactly one result on the m_axis channel: a status
// (ok, would_block, not_open, none_free), the byte read, the pipe opened by
// a create, and the addressed pipe's fill count after the request.
// A request accepted on s_axis is held in the input register; its result
// then goes to the result register (the read byte to the store's read
// register) and is offered on m_axis. Throughput: one request per cycle
// while the receiver takes results, set by the single pass through the control
// logic and the one write port and one registered read port of the byte store.
// If the receiver stalls, the result register holds and the input register
// still takes one more request; s_axis_tready then drops until the result
// is taken. Reset closes every pipe and clears pointers and counts; store
// contents are left as they are, since a pipe only reads back what it was
// given after its create.
`timescale 1ns / 1ps
`default_nettype none
module multi_channel_byte_pipe #(
	parameter int NUM_PIPES  = mcbp_pkg::NUM_PIPES_DEF,
	parameter int PIPE_DEPTH = mcbp_pkg::PIPE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	// [1:0] operation, [3:2] pipe_index, [11:4] write_byte, [15:12] zero
	input  wire logic [15:0] s_axis_tdata,
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [1:0] status, [9:2] read_byte, [11:10] opened_pipe, [15:12] fill_count
	output      logic [15:0] m_axis_tdata
);
	import mcbp_pkg::*;

	localparam int DEPTH = NUM_PIPES * PIPE_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Input stage
	logic                vld_s1;
	logic [OP_W-1:0]     op_s1;
	logic [INDEX_W-1:0]  idx_s1;
	logic [BYTE_W-1:0]   wb_s1;

	// Result stage
	logic                vld_s2;
	res_t                res_s2;
	logic [BYTE_W-1:0]   rdata_s2;

	res_t                res;
	logic                mem_we;
	logic                mem_re;
	logic [AW-1:0]       mem_waddr;
	logic [AW-1:0]       mem_raddr;
	logic                s2_free;
	logic                advance;
	logic                take;
	logic [BYTE_W-1:0]   read_byte;

	// Advance the input stage when the result stage is empty or being drained.
	assign s2_free       = !vld_s2 || m_axis_tready;
	assign advance       = vld_s1 && s2_free;
	assign s_axis_tready = !vld_s1 || s2_free;
	assign take          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= take || (vld_s1 && !advance);
			vld_s2 <= advance || (vld_s2 && !m_axis_tready);
		end
	end

	// Payload registers: load the request on accept, the result on advance.
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= s_axis_tdata[1:0];
			idx_s1 <= s_axis_tdata[3:2];
			wb_s1  <= s_axis_tdata[11:4];
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	mcbp_ctrl #(
		.NUM_PIPES  (NUM_PIPES),
		.PIPE_DEPTH (PIPE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.op_s1     (op_s1),
		.idx_s1    (idx_s1),
		.res       (res),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_waddr (mem_waddr),
		.mem_raddr (mem_raddr)
	);

	mcbp_store #(
		.NUM_PIPES  (NUM_PIPES),
		.PIPE_DEPTH (PIPE_DEPTH)
	) u_store (
		.clk      (clk),
		.we       (mem_we),
		.waddr    (mem_waddr),
		.wdata    (wb_s1),
		.re       (mem_re),
		.raddr    (mem_raddr),
		.rdata_s2 (rdata_s2)
	);

	// Drop the store output unless this result is a successful read.
	assign read_byte     = res_s2.rd_hit ? rdata_s2 : '0;
	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {res_s2.fill_count, res_s2.opened_pipe, read_byte, res_s2.status};

	// The input side only stalls when both stages are full and the output is held.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (vld_s1 && vld_s2 && !m_axis_tready))
		else $error("input stalled while a stage was free");

	// A request on a closed pipe carries neither data nor a count.
	a_not_open_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_s2.status == ST_NOT_OPEN) |->
			(res_s2.fill_count == '0 && read_byte == '0))
		else $error("not_open result with data or count");

	// Only a successful read returns a store byte.
	a_hit_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_s2.rd_hit) |-> (res_s2.status == ST_OK))
		else $error("read byte returned on a failed request");

	// A nonzero opened pipe only comes from a successful create.
	a_open_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_s2.opened_pipe != '0) |->
			(res_s2.status == ST_OK && !res_s2.rd_hit))
		else $error("opened pipe reported on a non-create result");

endmodule
`default_nettype wire
